@@ rtl/u8lb_pkg.sv @@
package u8lb_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int START_W         = 32;
    localparam int CP_W            = 21;

    localparam logic [CP_W-1:0] CP_REPL    = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
    localparam logic [CP_W-1:0] CP_LF      = 21'h00000A;
    localparam logic [CP_W-1:0] CP_TAB     = 21'h000009;
    localparam logic [CP_W-1:0] CP_SPACE   = 21'h000020;
    localparam logic [CP_W-1:0] CP_HYPHEN  = 21'h00002D;

    localparam logic [1:0] BRK_NONE      = 2'd0;
    localparam logic [1:0] BRK_BEFORE    = 2'd1;
    localparam logic [1:0] BRK_AFTER     = 2'd2;
    localparam logic [1:0] BRK_MANDATORY = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [START_W-1:0] start_offset;
        logic [2:0]         byte_count;
        logic [1:0]         break_kind;
        logic               was_replaced;
        logic               last_result;
    } t_out;

endpackage

@@ rtl/utf8_decode_line_break_finder_core.sv @@
// Each byte is registered at the input, then its results in the result register.
// Throughput: 1 byte per cycle when each byte gives at most one result and no
// output stall; a byte giving N results (N up to 4, malformed flush) holds the
// input while the single result register issues them, one per unstalled cycle.
// Reset (i_rst_n low, synchronous): clears valids, held count, length, offset
// and break history; the held sequence bytes are not reset.
module utf8_decode_line_break_finder_core
    import u8lb_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    function automatic logic f_is_script(input logic [CP_W-1:0] c);
        f_is_script = (c >= 21'h000E00 && c <= 21'h000E7F) ||
                      (c >= 21'h003040 && c <= 21'h0030FF) ||
                      (c >= 21'h003400 && c <= 21'h004DBF) ||
                      (c >= 21'h004E00 && c <= 21'h009FFF) ||
                      (c >= 21'h00F900 && c <= 21'h00FAFF);
    endfunction

    logic                   r_in_valid;
    t_in                    r_in;
    logic                   r_out_valid;
    t_out                   r_out;
    logic [1:0]             r_idx;
    logic [7:0]             r_held [3];
    logic [1:0]             r_hcnt;
    logic [2:0]             r_elen;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_prev_script;

    logic                   n_in_valid;
    logic                   n_out_valid;
    t_out                   n_out;
    logic [1:0]             n_idx;
    logic [1:0]             n_hcnt;
    logic [2:0]             n_elen;
    logic [OFFSET_BITS-1:0] n_offset;
    logic                   n_prev_script;

    logic [7:0]             b;
    logic                   eot;
    logic                   is_cont;
    logic                   case_a;
    logic                   complete;
    logic [2:0]             h_f;
    logic [2:0]             fresh_len;
    logic                   fresh_lead;
    logic                   main_v;
    logic [CP_W-1:0]        asm_cp;
    logic                   bad;
    logic [CP_W-1:0]        main_cp;
    logic                   main_repl;
    logic [2:0]             main_cnt;
    logic [OFFSET_BITS-1:0] main_start;
    logic [1:0]             main_kind;
    logic [1:0]             h_after;
    logic [2:0]             h_e;
    logic [2:0]             n_res;
    logic [2:0]             k3;
    logic                   is_main;
    logic [OFFSET_BITS-1:0] off_p1;
    logic [OFFSET_BITS-1:0] rep_start;
    logic [OFFSET_BITS-1:0] slot_start;
    logic                   avail;
    logic                   step;
    logic                   last_slot;
    logic                   consume;
    logic                   accept;

    always_comb begin
        b       = r_in.text_byte;
        eot     = r_in.end_of_text;
        is_cont = (b[7:6] == 2'b10);
        case_a  = (r_hcnt != 2'd0) && is_cont;
        complete = case_a && (({1'b0, r_hcnt} + 3'd1) >= r_elen);
        h_f     = ((r_hcnt != 2'd0) && !is_cont) ? {1'b0, r_hcnt} : 3'd0;

        if (!b[7]) begin
            fresh_len = 3'd0;
        end else if (b[7:5] == 3'b110) begin
            fresh_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            fresh_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            fresh_len = 3'd4;
        end else begin
            fresh_len = 3'd0;
        end
        fresh_lead = !case_a && (fresh_len != 3'd0);
        main_v     = complete || (!case_a && !fresh_lead);

        case (r_elen)
            3'd2: asm_cp = {10'd0, r_held[0][4:0], b[5:0]};
            3'd3: asm_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], b[5:0]};
            default: asm_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], b[5:0]};
        endcase
        bad = (r_elen == 3'd2 && asm_cp < CP_MIN2) ||
              (r_elen == 3'd3 && asm_cp < CP_MIN3) ||
              (r_elen == 3'd4 && asm_cp < CP_MIN4) ||
              (asm_cp >= CP_SURR_LO && asm_cp <= CP_SURR_HI) ||
              (asm_cp > CP_MAX);

        if (complete) begin
            main_cp    = bad ? CP_REPL : asm_cp;
            main_repl  = bad;
            main_cnt   = r_elen;
            main_start = r_offset - OFFSET_BITS'(r_hcnt);
        end else begin
            main_cp    = b[7] ? CP_REPL : {13'd0, b};
            main_repl  = b[7];
            main_cnt   = 3'd1;
            main_start = r_offset;
        end

        if (main_cp == CP_LF) begin
            main_kind = BRK_MANDATORY;
        end else if (main_cp == CP_SPACE || main_cp == CP_TAB || main_cp == CP_HYPHEN) begin
            main_kind = BRK_AFTER;
        end else if (h_f == 3'd0 && r_prev_script && f_is_script(main_cp)) begin
            main_kind = BRK_BEFORE;
        end else begin
            main_kind = BRK_NONE;
        end

        if (complete) begin
            h_after = 2'd0;
        end else if (case_a) begin
            h_after = 2'(r_hcnt + 2'd1);
        end else if (fresh_lead) begin
            h_after = 2'd1;
        end else begin
            h_after = 2'd0;
        end
        h_e   = eot ? {1'b0, h_after} : 3'd0;
        n_res = h_f + {2'd0, main_v} + h_e;

        k3      = {1'b0, r_idx};
        is_main = main_v && (k3 == h_f);
        off_p1  = r_offset + OFFSET_BITS'(1);
        if (k3 < h_f) begin
            rep_start = r_offset - OFFSET_BITS'(r_hcnt) + OFFSET_BITS'(r_idx);
        end else begin
            rep_start = off_p1 - OFFSET_BITS'(h_e) + OFFSET_BITS'(r_idx)
                        - OFFSET_BITS'(h_f) - OFFSET_BITS'(main_v);
        end
        slot_start = is_main ? main_start : rep_start;

        avail     = !r_out_valid || !i_out_stall;
        step      = r_in_valid && avail;
        last_slot = (n_res == 3'd0) || (k3 == (n_res - 3'd1));
        consume   = step && last_slot;
        o_in_stall = r_in_valid && !consume;
        accept    = i_in_valid && !o_in_stall;

        n_out = r_out;
        n_out.start_offset = '0;
        n_out.start_offset[OFFSET_BITS-1:0] = slot_start;
        if (is_main) begin
            n_out.code_point   = main_cp;
            n_out.byte_count   = main_cnt;
            n_out.break_kind   = main_kind;
            n_out.was_replaced = main_repl;
        end else begin
            n_out.code_point   = CP_REPL;
            n_out.byte_count   = 3'd1;
            n_out.break_kind   = BRK_NONE;
            n_out.was_replaced = 1'b1;
        end
        n_out.last_result = last_slot;

        if (step && n_res != 3'd0) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        if (accept) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end

        if (consume) begin
            n_idx = 2'd0;
        end else if (step) begin
            n_idx = r_idx + 2'd1;
        end else begin
            n_idx = r_idx;
        end

        n_hcnt = eot ? 2'd0 : h_after;
        if (eot || complete) begin
            n_elen = 3'd0;
        end else if (case_a) begin
            n_elen = r_elen;
        end else begin
            n_elen = fresh_len;
        end
        n_offset = eot ? '0 : off_p1;
        if (eot) begin
            n_prev_script = 1'b0;
        end else if (main_v) begin
            n_prev_script = f_is_script(main_cp);
        end else if (h_f != 3'd0) begin
            n_prev_script = 1'b0;
        end else begin
            n_prev_script = r_prev_script;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_idx         <= 2'd0;
            r_hcnt        <= 2'd0;
            r_elen        <= 3'd0;
            r_offset      <= '0;
            r_prev_script <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            if (consume) begin
                r_hcnt        <= n_hcnt;
                r_elen        <= n_elen;
                r_offset      <= n_offset;
                r_prev_script <= n_prev_script;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (step && n_res != 3'd0) begin
            r_out <= n_out;
        end
        if (consume && case_a && !complete) begin
            r_held[r_hcnt] <= b;
        end else if (consume && fresh_lead) begin
            r_held[0] <= b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ tb/sv/utf8_decode_line_break_finder_core_tb.sv @@
`timescale 1ns / 1ps

module utf8_decode_line_break_finder_core_tb;
    import u8lb_pkg::*;

    class cp_scoreboard;
        t_out        decoded_q[$];
        t_out        step_q[$];
        int          fails;
        logic [7:0]  seq_bytes[3];
        int unsigned seq_cnt;
        int unsigned seq_len;
        logic [31:0] next_off;
        logic [20:0] prev_cp;

        function new();
            fails    = 0;
            seq_cnt  = 0;
            seq_len  = 0;
            next_off = '0;
            prev_cp  = '0;
        endfunction

        function bit no_space_script(logic [20:0] c);
            return (c >= 21'h00E00 && c <= 21'h00E7F) ||
                   (c >= 21'h03040 && c <= 21'h030FF) ||
                   (c >= 21'h03400 && c <= 21'h04DBF) ||
                   (c >= 21'h04E00 && c <= 21'h09FFF) ||
                   (c >= 21'h0F900 && c <= 21'h0FAFF);
        endfunction

        function void push_char(logic [20:0] cp, logic [31:0] start, logic [2:0] cnt,
                                logic repl);
            t_out r;
            if (step_q.size() >= 4)
                return;
            if (cp == CP_LF)
                r.break_kind = BRK_MANDATORY;
            else if (cp == CP_SPACE || cp == CP_TAB || cp == CP_HYPHEN)
                r.break_kind = BRK_AFTER;
            else if (prev_cp != '0 && no_space_script(cp) && no_space_script(prev_cp))
                r.break_kind = BRK_BEFORE;
            else
                r.break_kind = BRK_NONE;
            prev_cp        = cp;
            r.code_point   = cp;
            r.start_offset = start;
            r.byte_count   = cnt;
            r.was_replaced = repl;
            r.last_result  = 1'b0;
            step_q = {step_q, r};
        endfunction

        function void flush_seq(logic [31:0] after);
            for (int unsigned i = 0; i < seq_cnt; i++)
                push_char(CP_REPL, after - seq_cnt + i, 3'd1, 1'b1);
            seq_cnt = 0;
            seq_len = 0;
        endfunction

        function void note_byte(t_in item);
            logic [7:0]  b;
            logic [31:0] off;
            logic [31:0] cp;
            bit          used;
            bit          bad;
            int unsigned len;
            b    = item.text_byte;
            off  = next_off;
            used = 1'b0;
            step_q.delete();
            if (seq_cnt > 0) begin
                if (b[7:6] == 2'b10) begin
                    used = 1'b1;
                    if (seq_cnt + 1 >= seq_len) begin
                        case (seq_len)
                            2: cp = {24'd0, seq_bytes[0] & 8'h1F};
                            3: cp = {24'd0, seq_bytes[0] & 8'h0F};
                            default: cp = {24'd0, seq_bytes[0] & 8'h07};
                        endcase
                        for (int unsigned i = 1; i < seq_cnt; i++)
                            cp = (cp << 6) | {26'd0, seq_bytes[i][5:0]};
                        cp = (cp << 6) | {26'd0, b[5:0]};
                        bad = (seq_len == 2 && cp < 32'h80) ||
                              (seq_len == 3 && cp < 32'h800) ||
                              (seq_len == 4 && cp < 32'h10000) ||
                              (cp >= 32'hD800 && cp <= 32'hDFFF) || cp > 32'h10FFFF;
                        push_char(bad ? CP_REPL : cp[20:0], off - seq_cnt, 3'(seq_len), bad);
                        seq_cnt = 0;
                        seq_len = 0;
                    end else begin
                        seq_bytes[seq_cnt] = b;
                        seq_cnt++;
                    end
                end else begin
                    flush_seq(off);
                end
            end
            if (!used) begin
                len = 0;
                if (b[7] == 1'b0)
                    push_char({13'd0, b}, off, 3'd1, 1'b0);
                else if (b[7:5] == 3'b110)
                    len = 2;
                else if (b[7:4] == 4'b1110)
                    len = 3;
                else if (b[7:3] == 5'b11110)
                    len = 4;
                else
                    push_char(CP_REPL, off, 3'd1, 1'b1);
                if (len != 0) begin
                    seq_bytes[0] = b;
                    seq_cnt      = 1;
                    seq_len      = len;
                end
            end
            next_off = off + 1;
            if (item.end_of_text) begin
                flush_seq(next_off);
                next_off = '0;
                prev_cp  = '0;
            end
            if (step_q.size() > 0)
                step_q[step_q.size()-1].last_result = 1'b1;
            foreach (step_q[k])
                decoded_q = {decoded_q, step_q[k]};
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_code_point(t_out got);
            t_out want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected transaction, actual code_point %h offset %h",
                         $time, got.code_point, got.start_offset);
                fails++;
                return;
            end
            want = decoded_q.pop_front();
            cmp_field("code_point", 32'(want.code_point), 32'(got.code_point));
            cmp_field("start_offset", want.start_offset, got.start_offset);
            cmp_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
            cmp_field("break_kind", 32'(want.break_kind), 32'(got.break_kind));
            cmp_field("was_replaced", 32'(want.was_replaced), 32'(got.was_replaced));
            cmp_field("last_result", 32'(want.last_result), 32'(got.last_result));
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    cp_scoreboard sb = new();
    int           in_idle_pct  = 8;
    int           out_idle_pct = 81;
    logic [7:0]   unit_q[$];
    logic [7:0]   directed_q[$];

    utf8_decode_line_break_finder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_code_point(o_out_data);
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        t_in item;
        item.text_byte   = b;
        item.end_of_text = eot;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(item);
    endtask

    function automatic void add_unit(logic [7:0] u);
        unit_q = {unit_q, u};
    endfunction

    function automatic void encode_cp(logic [20:0] cp, int len);
        case (len)
            1: add_unit({1'b0, cp[6:0]});
            2: begin
                add_unit({3'b110, cp[10:6]});
                add_unit({2'b10, cp[5:0]});
            end
            3: begin
                add_unit({4'b1110, cp[15:12]});
                add_unit({2'b10, cp[11:6]});
                add_unit({2'b10, cp[5:0]});
            end
            default: begin
                add_unit({5'b11110, cp[20:18]});
                add_unit({2'b10, cp[17:12]});
                add_unit({2'b10, cp[11:6]});
                add_unit({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] cjk_thai_cp();
        case ($urandom_range(4))
            0: return 21'($urandom_range(32'h0E7F, 32'h0E00));
            1: return 21'($urandom_range(32'h30FF, 32'h3040));
            2: return 21'($urandom_range(32'h4DBF, 32'h3400));
            3: return 21'($urandom_range(32'h9FFF, 32'h4E00));
            default: return 21'($urandom_range(32'hFAFF, 32'hF900));
        endcase
    endfunction

    function automatic void build_unit();
        logic [20:0] cp;
        logic [7:0]  ascii_special[6];
        int          len;
        ascii_special = '{8'h0A, 8'h20, 8'h09, 8'h2D, 8'h00, 8'h7F};
        unit_q.delete();
        if ($urandom_range(99) < 70) begin
            case ($urandom_range(9))
                0, 1, 2, 9: begin
                    if ($urandom_range(2) == 0)
                        cp = {13'd0, ascii_special[$urandom_range(5)]};
                    else
                        cp = 21'($urandom_range(127));
                    encode_cp(cp, 1);
                end
                3: encode_cp(21'($urandom_range(32'h7FF, 32'h80)), 2);
                4, 5, 6: encode_cp(cjk_thai_cp(), 3);
                7: begin
                    cp = 21'($urandom_range(32'hFFFF, 32'h800));
                    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                        cp = cp + 21'h800;
                    encode_cp(cp, 3);
                end
                default: encode_cp(21'($urandom_range(32'h10FFFF, 32'h10000)), 4);
            endcase
        end else begin
            case ($urandom_range(7))
                0: begin
                    len = $urandom_range(4, 2);
                    if (len == 2)
                        cp = 21'($urandom_range(32'h7F));
                    else if (len == 3)
                        cp = 21'($urandom_range(32'h7FF));
                    else
                        cp = 21'($urandom_range(32'hFFFF));
                    encode_cp(cp, len);
                end
                1: encode_cp(21'($urandom_range(32'hDFFF, 32'hD800)), 3);
                2: encode_cp(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
                3: begin
                    len = $urandom_range(4, 2);
                    encode_cp(21'($urandom_range(32'h10FFFF, 32'h80)), len);
                    repeat ($urandom_range(len - 1, 1)) void'(unit_q.pop_back());
                end
                4: repeat ($urandom_range(3, 1))
                    add_unit(8'($urandom_range(8'hBF, 8'h80)));
                5: add_unit(8'($urandom_range(8'hFF, 8'hF8)));
                6: add_unit(8'($urandom_range(255)));
                default: begin
                    encode_cp(21'($urandom_range(32'hFFFF, 32'h80)), $urandom_range(3, 2));
                    add_unit(8'($urandom_range(8'hBF, 8'h80)));
                end
            endcase
        end
    endfunction

    initial begin
        int rand_sent;
        int wait_cnt;
        directed_q = '{8'h41, 8'h00, 8'h0A, 8'h20, 8'hC3, 8'hA9, 8'hC0, 8'h80,
                       8'hE0, 8'hB8, 8'h81, 8'hE4, 8'hB8, 8'h80, 8'hEF, 8'hBF,
                       8'hBD, 8'h80, 8'hFF, 8'hF5, 8'h80, 8'h80, 8'h80, 8'hF0,
                       8'h9F, 8'h98, 8'hC2};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bytes, ending in a truncated 4-byte lead, then a new lead with end of text: capped flush
        foreach (directed_q[i])
            send_byte(directed_q[i], i == directed_q.size() - 1);

        rand_sent = 0;
        while (rand_sent < 300) begin
            if (rand_sent >= 200) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else if (rand_sent >= 100) begin
                in_idle_pct  = 81;
                out_idle_pct = 8;
            end
            build_unit();
            foreach (unit_q[i]) begin
                send_byte(unit_q[i], $urandom_range(99) < 3);
                rand_sent++;
            end
        end
        send_byte(8'h0A, 1'b1);
        i_in_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.decoded_q.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (16) @(posedge i_clk);
        if (sb.fails == 0 && sb.decoded_q.size() == 0)
            $display("utf8_decode_line_break_finder_core test passed");
        else
            $display("utf8_decode_line_break_finder_core test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("utf8_decode_line_break_finder_core test failed");
        $finish;
    end

endmodule
